// ===== hdl/btc_pkg.sv =====
// Shared types, constants and helpers for the block transposition codec.
// No dependencies; every other file of the codec imports this package.
package btc_pkg;

  localparam int BYTE_W     = 8;
  localparam int DIM_W      = 4;
  localparam int ADDR_W     = 6;               // one cell of a block
  localparam int CNT_W      = ADDR_W + 1;      // holds the full cell count
  localparam int BANK_W     = 1;               // two blocks of storage
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [DIM_W-1:0] MAX_ROWS = 4'd8;
  localparam logic [DIM_W-1:0] MAX_COLS = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 2'd0,
    REG_ROWS = 2'd1,
    REG_COLS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN
  } back_state_t;

  // one finished block, handed from front to back
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [CNT_W-1:0]  cnt;
    logic              final_text;
    logic              decode;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
  } desc_t;

  typedef struct packed {
    logic                     en;
    logic [BANK_W+ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
  } release_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) res = 4'd1;
    else if (v > maxv) res = maxv;
    else res = v;
    return res;
  endfunction

endpackage

// ===== hdl/btc_if.sv =====
// Channel interfaces of the block transposition codec: text in, text out, config.
// Depends on btc_pkg for field widths.
interface btc_in_if import btc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              is_final;
  modport source (output valid, data_byte, is_final, input ready);
  modport sink   (input valid, data_byte, is_final, output ready);
endinterface

interface btc_out_if import btc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              block_end;
  logic              text_end;
  modport source (output valid, out_byte, block_end, text_end, input ready);
  modport sink   (input valid, out_byte, block_end, text_end, output ready);
endinterface

interface btc_cfg_if import btc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/btc_front.sv =====
// Front part: config registers, byte intake into the free bank, block closing.
// Depends on btc_pkg and btc_if.
module btc_front import btc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  btc_in_if.sink    text_in,
  btc_cfg_if.sink   cfg,
  output store_wr_t st_wr,
  output logic      push,
  output desc_t     push_desc,
  input  logic      q_full,
  input  release_t  rel
);

  logic                 mode_decode;
  logic [DIM_W-1:0]     row_count;
  logic [DIM_W-1:0]     col_count;
  logic [CNT_W-1:0]     fill_count;
  logic [BANK_W-1:0]    wr_bank;
  logic [1:0]           busy;
  logic [1:0]           busy_next;

  logic [DIM_W-1:0]     rows_eff;
  logic [DIM_W-1:0]     cols_eff;
  logic [2*DIM_W-1:0]   cells_full;
  logic [CNT_W-1:0]     cells;
  logic [CNT_W-1:0]     cnt_new;
  logic                 accept;
  logic                 close_blk;

  assign rows_eff   = eff_dim(row_count, MAX_ROWS);
  assign cols_eff   = eff_dim(col_count, MAX_COLS);
  assign cells_full = {4'b0, rows_eff} * {4'b0, cols_eff};
  assign cells      = cells_full[CNT_W-1:0];

  assign cfg.ready     = 1'b1;
  assign text_in.ready = !busy[wr_bank] && !q_full;
  assign accept        = text_in.valid && text_in.ready;
  assign cnt_new       = fill_count + 7'd1;
  assign close_blk     = accept && ((cnt_new == cells) || text_in.is_final);

  assign st_wr.en   = accept;
  assign st_wr.addr = {wr_bank, fill_count[ADDR_W-1:0]};
  assign st_wr.data = text_in.data_byte;

  assign push                 = close_blk;
  assign push_desc.bank       = wr_bank;
  assign push_desc.cnt        = cnt_new;
  assign push_desc.final_text = text_in.is_final;
  assign push_desc.decode     = mode_decode;
  assign push_desc.rows       = rows_eff;
  assign push_desc.cols       = cols_eff;

  // free a bank once the back has read it, claim a closed bank if cfg is idle
  always_comb begin
    busy_next = busy;
    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (close_blk && !cfg.valid) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_decode <= 1'b0;
      row_count   <= 4'd8;
      col_count   <= 4'd8;
      fill_count  <= '0;
      wr_bank     <= '0;
      busy        <= '0;
    end else begin
      busy <= busy_next;
      if (cfg.valid) begin
        // any listed register also drops the partial block
        unique case (cfg_reg_t'(cfg.index))
          REG_MODE: begin
            mode_decode <= cfg.data[0];
            fill_count  <= '0;
          end
          REG_ROWS: begin
            row_count  <= cfg.data;
            fill_count <= '0;
          end
          REG_COLS: begin
            col_count  <= cfg.data;
            fill_count <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        if (close_blk) begin
          wr_bank    <= ~wr_bank;
          fill_count <= '0;
        end else begin
          fill_count <= cnt_new;
        end
      end
    end
  end

endmodule

// ===== hdl/btc_queue.sv =====
// Two-entry queue of closed-block descriptors between front and back.
// Depends on btc_pkg.
module btc_queue import btc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  q_valid,
  output logic  q_full,
  output desc_t q_head
);

  desc_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);
  assign q_head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/btc_back.sv =====
// Back part: block store banks, row-major scan, decode reorder buffer, output stage.
// Depends on btc_pkg and btc_if.
module btc_back import btc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  store_wr_t st_wr,
  input  logic      q_valid,
  input  desc_t     q_head,
  output logic      q_pop,
  output release_t  rel,
  btc_out_if.source text_out
);

  logic [BYTE_W-1:0] store [2**(BANK_W+ADDR_W)];
  logic [BYTE_W-1:0] perm  [2**ADDR_W];

  back_state_t state, state_next;
  desc_t       cur;
  logic [2:0]  r, r_next;
  logic [2:0]  c, c_next;
  logic [CNT_W-1:0] k, k_next;
  logic [CNT_W-1:0] seq, seq_next;

  // read stage
  logic              p1_v;
  logic              p1_to_perm;
  logic              p1_src_perm;
  logic [ADDR_W-1:0] p1_dest;
  logic              p1_last;
  logic              p1_text;
  logic [BYTE_W-1:0] rd_store;
  logic [BYTE_W-1:0] rd_perm;

  // output stage
  logic              out_v;
  logic [BYTE_W-1:0] out_byte;
  logic              out_blk;
  logic              out_txt;

  logic                     adv;
  logic                     p1_go;
  logic                     cell_ok;
  logic                     last_one;
  logic                     row_wrap;
  logic                     issue;
  logic                     st_rd_en;
  logic [BANK_W+ADDR_W-1:0] st_rd_addr;
  logic                     pm_rd_en;
  logic                     n_to_perm;
  logic                     n_src_perm;
  logic [ADDR_W-1:0]        n_dest;

  assign adv      = !out_v || text_out.ready;
  assign p1_go    = p1_v && (p1_to_perm || adv);
  assign cell_ok  = (k < cur.cnt);
  assign last_one = (seq + 7'd1 == cur.cnt);
  assign row_wrap = ({1'b0, c} == cur.cols - 4'd1);

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    k_next     = k;
    seq_next   = seq;
    q_pop      = 1'b0;
    rel.en     = 1'b0;
    rel.bank   = cur.bank;
    issue      = 1'b0;
    st_rd_en   = 1'b0;
    st_rd_addr = {cur.bank, k[ADDR_W-1:0]};
    pm_rd_en   = 1'b0;
    n_to_perm  = 1'b0;
    n_src_perm = 1'b0;
    n_dest     = k[ADDR_W-1:0];
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          r_next     = '0;
          c_next     = '0;
          k_next     = '0;
          seq_next   = '0;
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        // cells beyond the byte count are skipped without a read
        if (!cell_ok || !p1_v || p1_go) begin
          if (cell_ok) begin
            issue    = 1'b1;
            st_rd_en = 1'b1;
            seq_next = seq + 7'd1;
            if (cur.decode) begin
              st_rd_addr = {cur.bank, seq[ADDR_W-1:0]};
              n_to_perm  = 1'b1;
            end
          end
          if (row_wrap) begin
            c_next = '0;
            r_next = r + 3'd1;
            k_next = {4'b0, r} + 7'd1;
          end else begin
            c_next = c + 3'd1;
            k_next = k + {3'b0, cur.rows};
          end
          if (cell_ok && last_one) begin
            rel.en     = 1'b1;
            seq_next   = '0;
            state_next = cur.decode ? B_DRAIN : B_IDLE;
          end
        end
      end
      B_DRAIN: begin
        // wait out the last reorder write before reading it back
        if (!p1_v || (p1_go && !p1_to_perm)) begin
          issue      = 1'b1;
          pm_rd_en   = 1'b1;
          n_src_perm = 1'b1;
          seq_next   = seq + 7'd1;
          if (last_one) begin
            state_next = B_IDLE;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_wr.en) begin
      store[st_wr.addr] <= st_wr.data;
    end
    if (st_rd_en) begin
      rd_store <= store[st_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (p1_go && p1_to_perm) begin
      perm[p1_dest] <= rd_store;
    end
    if (pm_rd_en) begin
      rd_perm <= perm[seq[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    r   <= r_next;
    c   <= c_next;
    k   <= k_next;
    seq <= seq_next;
    if (issue) begin
      p1_to_perm  <= n_to_perm;
      p1_src_perm <= n_src_perm;
      p1_dest     <= n_dest;
      p1_last     <= !n_to_perm && last_one;
      p1_text     <= !n_to_perm && last_one && cur.final_text;
    end
    if (p1_go && !p1_to_perm) begin
      out_byte <= p1_src_perm ? rd_perm : rd_store;
      out_blk  <= p1_last;
      out_txt  <= p1_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      p1_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      if (issue) begin
        p1_v <= 1'b1;
      end else if (p1_go) begin
        p1_v <= 1'b0;
      end
      if (p1_go && !p1_to_perm) begin
        out_v <= 1'b1;
      end else if (text_out.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  assign text_out.valid     = out_v;
  assign text_out.out_byte  = out_byte;
  assign text_out.block_end = out_blk;
  assign text_out.text_end  = out_txt;

endmodule

// ===== hdl/block_transposition_codec.sv =====
// Top level of the block transposition codec: front, descriptor queue, back.
// Depends on btc_pkg, btc_if, btc_front, btc_queue and btc_back.
//
//  channel    dir  payload                          transaction
//  text_in    in   data_byte[7:0], is_final         valid && ready
//  text_out   out  out_byte[7:0], block_end,        valid && ready
//                  text_end
//  cfg        in   index[1:0], data[3:0]            valid && ready (ready always 1)
//
// The front takes one byte per cycle into whichever of two block banks is free.
// The back takes each descriptor in its idle state, then scans the block row by row
// at one cell per cycle while the read stage can move, skipped cells included, up to
// the last filled cell; decode then waits for the last reorder write and reads the
// reorder buffer out in fill order. One read stage and one output register sit in the
// back; a stalled output holds both, though reads bound for the reorder buffer go on.
// Intake stalls only when both banks hold blocks that still wait for the back.
// Reset is synchronous; it clears control state only, no clearing pass is run.
module block_transposition_codec import btc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  btc_in_if.sink    text_in,
  btc_out_if.source text_out,
  btc_cfg_if.sink   cfg
);

  store_wr_t st_wr;
  logic      push;
  desc_t     push_desc;
  logic      pop;
  logic      q_valid;
  logic      q_full;
  desc_t     q_head;
  release_t  rel;

  // accept bytes, hold config, close blocks into a bank
  btc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .cfg       (cfg),
    .st_wr     (st_wr),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full),
    .rel       (rel)
  );

  // decouple block closing from emission
  btc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_head    (q_head)
  );

  // permute and emit; free the bank once its last byte is read
  btc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .st_wr    (st_wr),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (pop),
    .rel      (rel),
    .text_out (text_out)
  );

endmodule
